### hw/rtl/esc_pkg.sv
package esc_pkg;

    // Most data bytes a single input byte can produce (a failed hex escape
    // followed by an ordinary character); the terminator comes on top.
    localparam int DATA_SLOTS  = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_OCT,
        MODE_HEXWAIT,
        MODE_HEX
    } mode_t;

    // Results caused by one input byte, as handed from the parser to the emitter.
    typedef struct packed {
        logic [DATA_SLOTS-1:0][7:0] data;
        logic [1:0]                 data_cnt;
        logic                       term;
    } esc_ops_t;

endpackage

### hw/rtl/escape_sequence_collapser.sv
// Streaming decoder for C-style string escapes.
// Input channel (s_valid/s_ready): one source byte per transfer with s_in_last
// marking the end of a string; a zero byte also ends it. Result channel
// (m_valid/m_ready): decoded bytes, then a zero terminator flagged m_out_last,
// each with m_out_count, the number of bytes written for the string so far.
// cfg_wr_en/cfg_wr_data set the buffer capacity, terminator included; it is
// sampled by the first byte of each string and must change only while idle.
// Results pass through the queue, the entry register and the output register.
// Throughput while m_ready stays high: one input byte per cycle while each byte
// yields at most one result; the emitter delivers one result per cycle, so a
// byte that yields two to four results occupies it until its last result is
// taken. The parser hands work to the emitter through a four-entry queue, and
// s_ready drops only when that queue is full, so a stall on the result channel
// reaches the input only after the queue has filled. m_valid and the result
// payload hold while m_ready is low. Reset empties the queue and output register,
// sets the capacity to 65535 and starts a new string at the next byte.
module escape_sequence_collapser
    import esc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [LENGTH_WIDTH-1:0] cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_in_byte,
    input  logic                    s_in_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_out_last,
    output logic [LENGTH_WIDTH-1:0] m_out_count
);

    localparam int OPS_W   = $bits(esc_ops_t);
    localparam int ENTRY_W = OPS_W + LENGTH_WIDTH;

    logic                    in_fire;
    logic                    push;
    esc_ops_t                f_ops;
    logic [LENGTH_WIDTH-1:0] f_base;
    logic [ENTRY_W-1:0]      q_out;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    esc_ops_t                q_ops;
    logic [LENGTH_WIDTH-1:0] q_base;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;
    assign q_ops   = esc_ops_t'(q_out[ENTRY_W-1:LENGTH_WIDTH]);
    assign q_base  = q_out[LENGTH_WIDTH-1:0];

    esc_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_fire    (in_fire),
        .in_byte    (s_in_byte),
        .in_last    (s_in_last),
        .push       (push),
        .ops        (f_ops),
        .base_count (f_base)
    );

    esc_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data({f_ops, f_base}),
        .pop      (q_pop),
        .pop_data (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    esc_back #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_ops      (q_ops),
        .q_base     (q_base),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .m_out_count(m_out_count)
    );

endmodule

### hw/rtl/esc_front.sv
module esc_front
    import esc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [LENGTH_WIDTH-1:0] cfg_wr_data,
    input  logic                    in_fire,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    output logic                    push,
    output esc_ops_t                ops,
    output logic [LENGTH_WIDTH-1:0] base_count
);

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_NL     = 8'h0A;

    // Returns {valid, value} for a hex digit in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Returns {valid, byte} for the single-letter escapes.
    function automatic logic [8:0] letter_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            default: r = '0;
        endcase
        return r;
    endfunction

    logic [LENGTH_WIDTH-1:0] cap_reg, cap_next;
    mode_t                   mode_reg, mode_next;
    logic [7:0]              acc_reg, acc_next;
    logic [1:0]              dc_reg, dc_next;
    logic [LENGTH_WIDTH-1:0] room_reg, room_next;
    logic [LENGTH_WIDTH-1:0] wr_reg, wr_next;
    logic                    at_start_reg, at_start_next;

    logic [LENGTH_WIDTH-1:0] room_cur;
    logic [LENGTH_WIDTH-1:0] wr_cur;
    logic [1:0]              avail;
    logic                    is_end;
    logic                    is_bs;
    logic                    is_oct;
    logic [4:0]              hex;
    logic [8:0]              letter;
    logic [7:0]              oct_acc;
    logic [1:0]              oct_dc;
    mode_t                   mode_mid;
    logic [7:0]              acc_mid;
    logic [DATA_SLOTS-1:0][7:0] att;
    logic [1:0]              att_n;
    logic [1:0]              emit_n;
    logic                    term;

    assign room_cur = at_start_reg ? cap_reg : room_reg;
    assign wr_cur   = at_start_reg ? '0 : wr_reg;
    assign is_end   = (in_byte == 8'd0) || in_last;
    assign is_bs    = (in_byte == CHAR_BSLASH);
    assign is_oct   = (in_byte inside {[8'h30:8'h37]});
    assign hex      = hex_digit(in_byte);
    assign letter   = letter_escape(in_byte);
    assign oct_acc  = {acc_reg[4:0], in_byte[2:0]};
    assign oct_dc   = dc_reg + 2'd1;

    // Data slots left with one kept for the terminator, capped at what one byte can use.
    always_comb begin
        if (room_cur >= LENGTH_WIDTH'(4)) begin
            avail = 2'd3;
        end else if (room_cur > LENGTH_WIDTH'(1)) begin
            avail = 2'(room_cur - LENGTH_WIDTH'(1));
        end else begin
            avail = 2'd0;
        end
    end

    // Next parser state and the data bytes the byte tries to emit, in order.
    // A backslash met as plain text opens an escape only if there is room for data.
    always_comb begin
        mode_mid  = mode_reg;
        acc_mid   = acc_reg;
        dc_next   = dc_reg;
        att       = '0;
        att_n     = 2'd0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        if (in_byte != 8'd0) begin
            case (mode_reg)
                MODE_ESC: begin
                    mode_mid = MODE_NORMAL;
                    if (in_byte == CHAR_NL) begin
                        att_n = 2'd0;
                    end else if (is_bs) begin
                        att[0] = CHAR_BSLASH;
                        att_n  = 2'd1;
                    end else if (letter[8]) begin
                        att[0] = letter[7:0];
                        att_n  = 2'd1;
                    end else if (in_byte == CHAR_X) begin
                        mode_mid = MODE_HEXWAIT;
                        acc_mid  = 8'd0;
                    end else if (is_oct) begin
                        mode_mid = MODE_OCT;
                        acc_mid  = {5'd0, in_byte[2:0]};
                        dc_next  = 2'd1;
                    end else begin
                        att[0] = CHAR_BSLASH;
                        att[1] = in_byte;
                        att_n  = 2'd2;
                    end
                end
                MODE_OCT: begin
                    if (is_oct) begin
                        if (oct_dc == 2'd3) begin
                            att[0]   = oct_acc;
                            att_n    = 2'd1;
                            mode_mid = MODE_NORMAL;
                            acc_mid  = 8'd0;
                            dc_next  = 2'd0;
                        end else begin
                            acc_mid = oct_acc;
                            dc_next = oct_dc;
                        end
                    end else begin
                        att[0]   = acc_reg;
                        att_n    = 2'd1;
                        mode_mid = MODE_NORMAL;
                        acc_mid  = 8'd0;
                        dc_next  = 2'd0;
                        if (is_bs) begin
                            if (avail > 2'd1) begin
                                mode_mid = MODE_ESC;
                            end
                        end else begin
                            att[1] = in_byte;
                            att_n  = 2'd2;
                        end
                    end
                end
                MODE_HEXWAIT: begin
                    if (hex[4]) begin
                        acc_mid  = {4'd0, hex[3:0]};
                        mode_mid = MODE_HEX;
                    end else begin
                        att[0]   = CHAR_BSLASH;
                        att[1]   = CHAR_X;
                        att_n    = 2'd2;
                        mode_mid = MODE_NORMAL;
                        if (is_bs) begin
                            if (avail > 2'd2) begin
                                mode_mid = MODE_ESC;
                            end
                        end else begin
                            att[2] = in_byte;
                            att_n  = 2'd3;
                        end
                    end
                end
                MODE_HEX: begin
                    if (hex[4]) begin
                        acc_mid = {acc_reg[3:0], hex[3:0]};
                    end else begin
                        att[0]   = acc_reg;
                        att_n    = 2'd1;
                        mode_mid = MODE_NORMAL;
                        acc_mid  = 8'd0;
                        if (is_bs) begin
                            if (avail > 2'd1) begin
                                mode_mid = MODE_ESC;
                            end
                        end else begin
                            att[1] = in_byte;
                            att_n  = 2'd2;
                        end
                    end
                end
                default: begin
                    mode_mid = MODE_NORMAL;
                    if (is_bs) begin
                        if (avail > 2'd0) begin
                            mode_mid = MODE_ESC;
                        end
                    end else begin
                        att[0] = in_byte;
                        att_n  = 2'd1;
                    end
                end
            endcase
        end
        mode_next = mode_mid;
        acc_next  = acc_mid;
        if (is_end) begin
            // An open numeric or hex escape only exists when this byte emitted
            // nothing, so the flushed bytes start at the first slot.
            case (mode_mid)
                MODE_OCT, MODE_HEX: begin
                    att[0] = acc_mid;
                    att_n  = 2'd1;
                end
                MODE_HEXWAIT: begin
                    att[0] = CHAR_BSLASH;
                    att[1] = CHAR_X;
                    att_n  = 2'd2;
                end
                default: begin
                end
            endcase
            mode_next = MODE_NORMAL;
            acc_next  = 8'd0;
            dc_next   = 2'd0;
        end
    end

    // Room accounting and the hand-off to the queue.
    always_comb begin
        emit_n        = (att_n < avail) ? att_n : avail;
        term          = is_end && (room_cur != '0);
        push          = in_fire && ((emit_n != 2'd0) || term);
        ops.data      = att;
        ops.data_cnt  = emit_n;
        ops.term      = term;
        base_count    = wr_cur;
        room_next     = room_cur - LENGTH_WIDTH'(emit_n) - LENGTH_WIDTH'(term);
        wr_next       = is_end ? '0 : wr_cur + LENGTH_WIDTH'(emit_n);
        at_start_next = is_end;
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= '1;
            mode_reg     <= MODE_NORMAL;
            acc_reg      <= 8'd0;
            dc_reg       <= 2'd0;
            room_reg     <= '1;
            wr_reg       <= '0;
            at_start_reg <= 1'b1;
        end else begin
            cap_reg <= cap_next;
            if (in_fire) begin
                mode_reg     <= mode_next;
                acc_reg      <= acc_next;
                dc_reg       <= dc_next;
                room_reg     <= room_next;
                wr_reg       <= wr_next;
                at_start_reg <= at_start_next;
            end
        end
    end

endmodule

### hw/rtl/esc_queue.sv
module esc_queue
    import esc_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/esc_back.sv
module esc_back
    import esc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  esc_ops_t                q_ops,
    input  logic [LENGTH_WIDTH-1:0] q_base,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_out_last,
    output logic [LENGTH_WIDTH-1:0] m_out_count
);

    esc_ops_t                cur_reg;
    logic [LENGTH_WIDTH-1:0] base_reg;
    logic [1:0]              idx_reg;
    logic                    cur_valid_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg;
    logic                    out_last_reg;
    logic [LENGTH_WIDTH-1:0] out_count_reg;

    logic [2:0]              total;
    logic [2:0]              idx_plus1;
    logic                    out_free;
    logic                    fire;
    logic                    cur_done;
    logic                    is_data;
    logic [7:0]              sel_byte;

    assign total     = {1'b0, cur_reg.data_cnt} + {2'b0, cur_reg.term};
    assign idx_plus1 = {1'b0, idx_reg} + 3'd1;
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = cur_valid_reg && out_free;
    assign cur_done  = fire && (idx_plus1 == total);
    assign q_pop     = !q_empty && (!cur_valid_reg || cur_done);
    assign is_data   = (idx_reg < cur_reg.data_cnt);

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.data[0];
            2'd1:    sel_byte = cur_reg.data[1];
            2'd2:    sel_byte = cur_reg.data[2];
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
            end else if (cur_done) begin
                cur_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg  <= q_ops;
            base_reg <= q_base;
            idx_reg  <= 2'd0;
        end else if (fire) begin
            idx_reg  <= idx_plus1[1:0];
        end
        if (fire) begin
            out_byte_reg  <= is_data ? sel_byte : 8'd0;
            out_last_reg  <= !is_data;
            out_count_reg <= base_reg + LENGTH_WIDTH'(idx_plus1);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_out_last  = out_last_reg;
    assign m_out_count = out_count_reg;

endmodule
